// ===== rtl/core/gls_pkg.sv =====
package gls_pkg;

  localparam int DATA_W = 32;
  localparam int RES_W  = 31;

  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_ENTRY   = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic        [RES_W-1:0]  residual;
    logic                     column_done;
    logic                     overflow;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_A,
    ST_UP_B,
    ST_HD_A,
    ST_HD_B,
    ST_GEN,
    ST_T_DIV,
    ST_TT,
    ST_ROOT,
    ST_INV,
    ST_OTHER,
    ST_DIAG_A,
    ST_DIAG_B,
    ST_RHS,
    ST_OUT
  } st_t;

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] x);
    mag32 = x[DATA_W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [64:0] x);
    if (x > 65'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (x < -65'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[DATA_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/gls_mul.sv =====
module gls_mul #(
  parameter int FRAC = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [63:0] res
);
  import gls_pkg::*;

  localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC - 1);

  logic        busy_r, fin_r, done_r, neg_r;
  logic [4:0]  cnt_r;
  logic [31:0] hi_r, lo_r, m_r;
  logic signed [63:0] res_r;
  logic [32:0] sum;
  logic signed [64:0] prod, rnd;

  // one multiplier bit per cycle: conditional add, then shift right
  assign sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, m_r} : 33'd0);
  assign prod = {1'b0, hi_r, lo_r};
  assign rnd  = neg_r ? (HALF - prod) : (prod + HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m_r   <= mag32(a);
      lo_r  <= mag32(b);
      hi_r  <= '0;
      neg_r <= a[31] ^ b[31];
    end else if (busy_r) begin
      hi_r <= sum[32:1];
      lo_r <= {sum[0], lo_r[31:1]};
    end else if (fin_r) begin
      res_r <= 64'(rnd >>> FRAC);
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== rtl/core/gls_div.sv =====
module gls_div #(
  parameter int FRAC = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  import gls_pkg::*;

  localparam int QB = FRAC + 1;

  logic        busy_r, done_r, ge;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r, lo_r, d_r, q_r;
  logic [32:0] trial;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, lo_r[31]};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(QB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 32'(num >> QB);
      lo_r  <= {num[FRAC:0], {(31 - FRAC){1'b0}}};
      d_r   <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? 32'(trial - {1'b0, d_r}) : trial[31:0];
      lo_r  <= {lo_r[30:0], 1'b0};
      q_r   <= {q_r[30:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== rtl/core/gls_sqrt.sv =====
module gls_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);
  import gls_pkg::*;

  logic        busy_r, done_r, ge;
  logic [4:0]  cnt_r;
  logic [63:0] n_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [35:0] rs, tr;

  // two radicand bits per cycle, one root bit out
  assign rs = {rem_r, n_r[63:62]};
  assign tr = {2'b00, root_r, 2'b01};
  assign ge = rs >= tr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? 34'(rs - tr) : rs[33:0];
      root_r <= {root_r[30:0], ge};
      n_r    <= {n_r[61:0], 2'b00};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/core/givens_least_squares_update.sv =====
// Givens least-squares update for restarted GMRES, Q.FRACTION_BITS fixed point.
// Input channel (in_valid/in_stall/in_data): a restart word loads beta into the
// running right-hand side; column words then stream in from the top row, the
// word with last set being the subdiagonal.
// Output channel (out_valid/out_stall/out_data): one word per column entry
// except restarts and a first entry that is not the last; the column-end word carries the
// rotated diagonal, the residual magnitude and column_done.
// A restart, or the first entry of a column that is not the last, only loads registers and leaves
// the block idle. Any other entry runs four rotation products through the bit-serial multiplier.
// A column end with a nonzero subdiagonal runs five products, two serial divisions
// of FRACTION_BITS+1 steps each and a 32-step square root; a column end with a zero
// subdiagonal runs three products only.
// The multiplier works one bit per cycle over 32 bits.
// One word is worked on at a time; in_stall is high while it is in progress.
// A finished result sits in the output register; the next word is accepted
// while it waits, and a second result holds until out_stall drops.
// Reset (rst_n low, synchronous) clears counters, held entry, right-hand side,
// overflow and output valid; the rotation store is not cleared.
module givens_least_squares_update #(
  parameter int MAX_COLUMNS   = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  gls_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output gls_pkg::out_t out_data
);
  import gls_pkg::*;

  localparam int RW  = $clog2(MAX_COLUMNS + 2);
  localparam int CLW = $clog2(MAX_COLUMNS + 1);
  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;

  st_t st_r, st_nxt;

  logic [31:0] cos_mem [MAX_COLUMNS];
  logic [31:0] sin_mem [MAX_COLUMNS];

  logic signed [31:0] held_r, rhs_r, dx_r, dy_r, rc_r, rs_r, c_r, s_r, t_r, elem_r;
  logic [31:0]        nmag_r, dmag_r, r_r, inv_r;
  logic [63:0]        qq_r;
  logic signed [63:0] acc_r;
  logic [RW-1:0]      row_r;
  logic [CLW-1:0]     col_r;
  logic               ovf_r, ident_r, swap_r, tneg_r, launched_r;
  logic               out_valid_r;
  out_t               out_r, out_nxt, pend_r;

  logic               accept, unit_done, launch, out_free;
  logic               mul_start, div_start, sqrt_start;
  logic               mul_done, div_done, sqrt_done;
  logic signed [31:0] mul_a, mul_b, c_eff, s_eff;
  logic signed [63:0] mul_res;
  logic [63:0]        div_num;
  logic [31:0]        div_den, div_q, sq_root;
  logic signed [31:0] rot_sum, new_rhs;
  logic [31:0]        adx, ady, rhs_mag;
  logic [RW-1:0]      k_row;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (st_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign unit_done = mul_done || div_done || sqrt_done;
  assign launch    = !launched_r;
  assign k_row     = row_r - RW'(1);

  assign c_eff   = ident_r ? ONE : rc_r;
  assign s_eff   = ident_r ? 32'sd0 : rs_r;
  assign rot_sum = sat32(65'(acc_r) + 65'(mul_res));
  assign new_rhs = sat32(65'(mul_res));
  assign rhs_mag = mag32(new_rhs);
  assign adx     = mag32(dx_r);
  assign ady     = mag32(dy_r);

  gls_mul #(.FRAC(FRACTION_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .res(mul_res)
  );

  gls_div #(.FRAC(FRACTION_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  gls_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .rad(qq_r),
    .done(sqrt_done), .root(sq_root)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (accept && in_data.kind == KIND_ENTRY) begin
          if (in_data.last) begin
            st_nxt = ST_GEN;
          end else if (row_r != '0) begin
            st_nxt = ST_UP_A;
          end
        end
      end
      ST_UP_A:   if (unit_done) st_nxt = ST_UP_B;
      ST_UP_B:   if (unit_done) st_nxt = ST_HD_A;
      ST_HD_A:   if (unit_done) st_nxt = ST_HD_B;
      ST_HD_B:   if (unit_done) st_nxt = ST_OUT;
      ST_GEN:    st_nxt = (dy_r == '0) ? ST_DIAG_A : ST_T_DIV;
      ST_T_DIV:  if (unit_done) st_nxt = ST_TT;
      ST_TT:     if (unit_done) st_nxt = ST_ROOT;
      ST_ROOT:   if (unit_done) st_nxt = ST_INV;
      ST_INV:    if (unit_done) st_nxt = ST_OTHER;
      ST_OTHER:  if (unit_done) st_nxt = ST_DIAG_A;
      ST_DIAG_A: if (unit_done) st_nxt = ST_DIAG_B;
      ST_DIAG_B: if (unit_done) st_nxt = ST_RHS;
      ST_RHS:    if (unit_done) st_nxt = ST_OUT;
      ST_OUT:    if (out_free) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // unit launches and operand selection
  always_comb begin
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_num    = '0;
    div_den    = '0;
    unique case (st_r)
      ST_UP_A:   begin mul_start = launch; mul_a = c_eff;  mul_b = held_r; end
      ST_UP_B:   begin mul_start = launch; mul_a = s_eff;  mul_b = dy_r;   end
      ST_HD_A:   begin mul_start = launch; mul_a = -s_eff; mul_b = held_r; end
      ST_HD_B:   begin mul_start = launch; mul_a = c_eff;  mul_b = dy_r;   end
      ST_T_DIV: begin
        div_start = launch;
        div_num   = ({32'd0, nmag_r} << FRACTION_BITS) + 64'(dmag_r >> 1);
        div_den   = dmag_r;
      end
      ST_TT:     begin mul_start = launch; mul_a = t_r; mul_b = t_r; end
      ST_ROOT:   sqrt_start = launch;
      ST_INV: begin
        div_start = launch;
        div_num   = (64'd1 << (2 * FRACTION_BITS)) + 64'(r_r >> 1);
        div_den   = r_r;
      end
      ST_OTHER:  begin mul_start = launch; mul_a = t_r;  mul_b = $signed(inv_r); end
      ST_DIAG_A: begin mul_start = launch; mul_a = c_r;  mul_b = dx_r;  end
      ST_DIAG_B: begin mul_start = launch; mul_a = s_r;  mul_b = dy_r;  end
      ST_RHS:    begin mul_start = launch; mul_a = -s_r; mul_b = rhs_r; end
      default: ;
    endcase
  end

  // result word for the output register
  always_comb begin
    out_nxt.element     = elem_r;
    out_nxt.residual    = '0;
    out_nxt.column_done = 1'b0;
    out_nxt.overflow    = ovf_r;
    if (st_r == ST_RHS) begin
      out_nxt.residual    = rhs_mag[31] ? {RES_W{1'b1}} : rhs_mag[RES_W-1:0];
      out_nxt.column_done = 1'b1;
      out_nxt.overflow    = ovf_r || (col_r == CLW'(MAX_COLUMNS));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      ovf_r       <= 1'b0;
      held_r      <= '0;
      rhs_r       <= '0;
    end else begin
      st_r <= st_nxt;
      if (unit_done) begin
        launched_r <= 1'b0;
      end else if (mul_start || div_start || sqrt_start) begin
        launched_r <= 1'b1;
      end

      if (st_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (accept) begin
        if (in_data.kind == KIND_RESTART) begin
          rhs_r  <= in_data.value;
          held_r <= '0;
          row_r  <= '0;
          col_r  <= '0;
          ovf_r  <= 1'b0;
        end else if (!in_data.last && row_r == '0) begin
          held_r <= in_data.value;
          row_r  <= RW'(1);
        end
      end

      if (st_r == ST_HD_B && unit_done) begin
        held_r <= rot_sum;
        if (row_r != RW'(MAX_COLUMNS + 1)) begin
          row_r <= row_r + RW'(1);
        end
      end

      // column end: commit rotation, advance right-hand side, reopen column
      if (st_r == ST_RHS && unit_done) begin
        rhs_r  <= new_rhs;
        held_r <= '0;
        row_r  <= '0;
        if (col_r != CLW'(MAX_COLUMNS)) begin
          col_r <= col_r + CLW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && in_data.kind == KIND_ENTRY) begin
      dy_r    <= in_data.value;
      dx_r    <= (row_r == '0) ? 32'sd0 : held_r;
      rc_r    <= cos_mem[k_row[CW-1:0]];
      rs_r    <= sin_mem[k_row[CW-1:0]];
      ident_r <= (row_r > RW'(MAX_COLUMNS));
    end

    if (st_r == ST_GEN) begin
      swap_r <= ady > adx;
      tneg_r <= dx_r[31] ^ dy_r[31];
      nmag_r <= (ady > adx) ? adx : ady;
      dmag_r <= (ady > adx) ? ady : adx;
      if (dy_r == '0) begin
        c_r <= ONE;
        s_r <= '0;
      end
    end

    if (unit_done) begin
      unique case (st_r)
        ST_UP_A, ST_HD_A, ST_DIAG_A: acc_r <= mul_res;
        ST_UP_B, ST_DIAG_B:          elem_r <= rot_sum;
        ST_T_DIV: t_r <= tneg_r ? -$signed(div_q) : $signed(div_q);
        ST_TT:    qq_r <= (64'($unsigned(mul_res)) + 64'(ONE)) << FRACTION_BITS;
        ST_ROOT:  r_r <= sq_root;
        ST_INV:   inv_r <= div_q;
        ST_OTHER: begin
          if (swap_r) begin
            s_r <= $signed(inv_r);
            c_r <= mul_res[31:0];
          end else begin
            c_r <= $signed(inv_r);
            s_r <= mul_res[31:0];
          end
        end
        default: ;
      endcase
    end

    // hold the finished word aside until the output register is free
    if ((st_r == ST_HD_B || st_r == ST_RHS) && unit_done) begin
      pend_r <= out_nxt;
    end

    if (st_r == ST_OUT && out_free) begin
      out_r <= pend_r;
    end
  end

  // rotation store, written once per column while room remains
  always_ff @(posedge clk) begin
    if (st_r == ST_RHS && unit_done && col_r != CLW'(MAX_COLUMNS)) begin
      cos_mem[col_r[CW-1:0]] <= c_r;
      sin_mem[col_r[CW-1:0]] <= s_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/gls_chk.sv =====
module gls_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input gls_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input gls_pkg::out_t out_data
);
  import gls_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_col_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == KIND_ENTRY && in_data.last |=> in_stall)
    else $error("column end did not occupy the block");

  a_restart_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == KIND_RESTART |=> !in_stall)
    else $error("restart left the block busy");

  a_residual_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.column_done |-> out_data.residual == '0)
    else $error("residual outside column end");

endmodule

bind givens_least_squares_update gls_chk u_gls_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);

// ===== dv/tb_givens_least_squares_update.sv =====
`timescale 1ns / 100ps

module tb_givens_least_squares_update;
  import gls_pkg::*;

  localparam int MAXC = 32;
  localparam int FB   = 24;
  localparam longint ONE_V  = 64'sd1 << FB;
  localparam longint HALF_V = 64'sd1 << (FB - 1);
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  givens_least_squares_update #(.MAX_COLUMNS(MAXC), .FRACTION_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Predictor state: a private copy of the rotation store and counters.
  longint cos_store [MAXC];
  longint sin_store [MAXC];
  longint held_v, rhs_v;
  int     row_cnt, col_cnt;
  bit     ovf_flag;

  in_t  word_queue [$];
  out_t rotated_queue [$];

  int  errors = 0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  cycles = 0;
  bit  long_holdoff_req = 1'b0;

  function automatic longint fshift(longint y);
    return y >>> FB;  // arithmetic shift is floor
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return fshift(a * b + HALF_V);
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint rotate(longint c, longint s, longint x, longint y);
    return clip32(fx_mul(c, x) + fx_mul(s, y));
  endfunction

  function automatic longint absval(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint fx_div(longint num, longint den);
    longint n, d, q;
    n = absval(num) << FB;
    d = absval(den);
    q = (n + d / 2) / d;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic longint inv_sqrt(longint t);
    longint q, r;
    q = ONE_V + fx_mul(t, t);
    r = int_sqrt(q << FB);
    return ((64'sd1 << (2 * FB)) + r / 2) / r;
  endfunction

  // Advance the predictor by one word; push the expected result if any.
  task automatic predict_rotation(in_t w);
    longint v, c, s, t, dx, up, diag, nr, mg;
    out_t e;
    v = longint'(w.value);
    if (w.kind == KIND_RESTART) begin
      rhs_v = v; held_v = 0; row_cnt = 0; col_cnt = 0; ovf_flag = 0;
      return;
    end
    if (!w.last) begin
      if (row_cnt == 0) begin
        held_v = v; row_cnt = 1;
        return;
      end
      if (row_cnt - 1 < MAXC) begin
        c = cos_store[row_cnt-1]; s = sin_store[row_cnt-1];
      end else begin
        c = ONE_V; s = 0;
      end
      up = rotate(c, s, held_v, v);
      held_v = rotate(-s, c, held_v, v);
      if (row_cnt < MAXC + 1) row_cnt++;
      e.element = up[31:0]; e.residual = '0; e.column_done = 1'b0;
      e.overflow = ovf_flag;
      rotated_queue.push_back(e);
      return;
    end
    dx = (row_cnt == 0) ? 0 : held_v;
    if (v == 0) begin
      c = ONE_V; s = 0;
    end else if (absval(v) > absval(dx)) begin
      t = fx_div(dx, v); s = inv_sqrt(t); c = fx_mul(t, s);
    end else begin
      t = fx_div(v, dx); c = inv_sqrt(t); s = fx_mul(t, c);
    end
    if (col_cnt < MAXC) begin
      cos_store[col_cnt] = clip32(c); sin_store[col_cnt] = clip32(s);
      col_cnt++;
    end else begin
      ovf_flag = 1;
    end
    diag = rotate(c, s, dx, v);
    nr = clip32(fx_mul(-s, rhs_v));
    rhs_v = nr; held_v = 0; row_cnt = 0;
    mg = absval(nr);
    if (mg > 64'sd2147483647) mg = 64'sd2147483647;
    e.element = diag[31:0]; e.residual = mg[30:0]; e.column_done = 1'b1;
    e.overflow = ovf_flag;
    rotated_queue.push_back(e);
  endtask

  function automatic logic signed [31:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return '0;
      3: return $urandom;
      4: return $signed($urandom_range(0, 255)) - 128;
      default: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    endcase
  endfunction

  task automatic add_word(logic k, logic signed [31:0] v, logic l);
    in_t w;
    w.kind = k; w.value = v; w.last = l;
    word_queue.push_back(w);
  endtask

  // A column of n entries, the last of them the subdiagonal.
  task automatic add_column(int n);
    for (int i = 0; i < n; i++) add_word(KIND_ENTRY, rand_entry(), i == n - 1);
  endtask

  // Capture the handshake at the rising edge so the driver sees the accept.
  logic in_stall_q = 1'b1;
  always @(posedge clk) in_stall_q <= in_stall | ~in_valid;

  // Driver: draw a gap before each word, hold the payload while stalled.
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_q) begin
        predict_rotation(in_data);
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      end else if (!in_valid) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (word_queue.size() > 0) begin
          in_data  <= word_queue.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Receiver stall: random per word, plus one long hold-off on request.
  int stall_left = 0;
  int long_left = 0;
  always @(negedge clk) begin
    if (long_holdoff_req && long_left == 0) begin
      long_left <= 3000;
      long_holdoff_req <= 1'b0;
      out_stall <= 1'b1;
    end else if (long_left > 0) begin
      long_left <= long_left - 1;
      out_stall <= (long_left > 1);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid) stall_left <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (rotated_queue.size() == 0) begin
        errors <= errors + 1;
        if (mismatches < 10) $display("unexpected result %h", out_data);
        mismatches <= mismatches + 1;
      end else begin
        e = rotated_queue.pop_front();
        if (e !== out_data) begin
          errors <= errors + 1;
          if (mismatches < 10)
            $display("mismatch: exp el=%h res=%h cd=%b ov=%b got el=%h res=%h cd=%b ov=%b",
                     e.element, e.residual, e.column_done, e.overflow,
                     out_data.element, out_data.residual, out_data.column_done,
                     out_data.overflow);
          mismatches <= mismatches + 1;
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (word_queue.size() > 0 || in_valid) @(posedge clk);
    while (rotated_queue.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    int n;
    held_v = 0; rhs_v = 0; row_cnt = 0; col_cnt = 0; ovf_flag = 0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: extremes, short and long columns, zero subdiagonal, lone last.
    add_word(KIND_RESTART, 32'sh7FFFFFFF, 1'b1);
    add_word(KIND_ENTRY, 32'sh0100_0000, 1'b1);
    add_word(KIND_ENTRY, 32'sh0100_0000, 1'b0);
    add_word(KIND_ENTRY, 32'sh0000_0000, 1'b1);
    add_word(KIND_ENTRY, 32'sh7FFFFFFF, 1'b0);
    add_word(KIND_ENTRY, 32'sh80000000, 1'b0);
    add_word(KIND_ENTRY, 32'sh80000000, 1'b1);
    add_word(KIND_ENTRY, 32'sh0000_0001, 1'b0);
    add_word(KIND_ENTRY, 32'shFF00_0000, 1'b1);
    add_word(KIND_ENTRY, 32'sh0000_0000, 1'b0);
    add_word(KIND_ENTRY, 32'sh0000_0000, 1'b1);
    add_word(KIND_RESTART, 32'sh80000000, 1'b0);
    add_word(KIND_ENTRY, 32'sh0200_0000, 1'b0);
    add_word(KIND_ENTRY, 32'sh7FFFFFFF, 1'b1);
    add_word(KIND_ENTRY, 32'sh0300_0000, 1'b0);
    add_word(KIND_ENTRY, 32'shFD00_0000, 1'b0);
    add_word(KIND_ENTRY, 32'sh0100_0000, 1'b1);
    wait_drained();

    // Pause the sender until drained, then fill the block under a long hold-off.
    add_word(KIND_RESTART, 32'sh0100_0000, 1'b0);
    add_column(1); add_column(2); add_column(3);
    long_holdoff_req = 1'b1;
    wait_drained();

    // Overflow: run past the rotation store with one-entry columns.
    add_word(KIND_RESTART, rand_entry(), 1'b0);
    for (int i = 0; i < MAXC + 3; i++) add_column(1);
    wait_drained();

    // Random: mostly well-formed restarts and columns, some noise.
    n = 0;
    while (n < 400) begin
      if ($urandom_range(0, 9) == 0) begin
        add_word(KIND_RESTART, rand_entry(), $urandom_range(0, 1));
        n++;
      end else begin
        int len;
        len = $urandom_range(0, 7) == 0 ? $urandom_range(1, 8) : $urandom_range(1, 4);
        add_column(len);
        n += len;
      end
      if (word_queue.size() > 40) begin
        while (word_queue.size() > 10) @(posedge clk);
      end
    end
    wait_drained();

    $display("Covered %0d results over restarts, columns of up to 8 entries,",
             results_seen);
    $display("store overflow, saturated extremes and long receiver hold-off.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
